### sv/imufd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imufd_pkg
// Types and fixed constants of the IMU frame deframer and angle filter.
// ----------------------------------------------------------------------------
package imufd_pkg;

  // Frame layout.
  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned POS_W       = 4;
  // Only bytes 1..7 of a frame are ever read back (type and three words).
  localparam int unsigned STORE_DEPTH = 7;
  localparam int unsigned STORE_IDX_W = 3;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  // Legal frame type range.
  localparam logic [7:0] TYPE_LOW  = 8'h50;
  localparam logic [7:0] TYPE_HIGH = 8'h5A;

  // Pitch clamp at +-90 degrees in raw units.
  localparam logic signed [15:0] PITCH_LIMIT = 16'sd16384;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMA_ALPHA,
    CFG_PITCH_DZ,
    CFG_YAW_DZ,
    CFG_STATIC_LIMIT,
    CFG_HEADER,
    CFG_ANGLE_CODE,
    CFG_GYRO_CODE
  } cfg_reg_e;

  localparam logic [15:0] RST_EMA_ALPHA    = 16'd6554;
  localparam logic [14:0] RST_PITCH_DZ     = 15'd18;
  localparam logic [14:0] RST_YAW_DZ       = 15'd18;
  localparam logic [31:0] RST_STATIC_LIMIT = 32'd67;
  localparam logic [7:0]  RST_HEADER       = 8'h55;
  localparam logic [7:0]  RST_ANGLE_CODE   = 8'h53;
  localparam logic [7:0]  RST_GYRO_CODE    = 8'h52;

  // Filter sequence that runs once per completed frame.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREP,
    PH_DIFF,
    PH_MUL,
    PH_ACC,
    PH_HOLD
  } phase_e;

endpackage : imufd_pkg
`default_nettype wire

### sv/imu_frame_deframer_angle_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_frame_deframer_angle_filter_top
// Serial IMU frame deframer with offset removal, EMA smoothing and deadzones.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle. Bytes outside a frame are
// dropped until the header byte opens one; the eleventh byte closes it and
// produces exactly one result item, while no other byte produces one. The
// result of a frame leaves through a fixed sequence of prepare, difference,
// multiply, accumulate and hold steps that share one set of registers. Only
// the closing byte of a frame is held off, and only while the result of the
// previous frame still waits on a stalled output. Configuration must be
// written while the block is idle; the block itself does not enforce this.
module imu_frame_deframer_angle_filter_top #(
  parameter int unsigned EMA_FRACTION_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           cfg_we_i,
  input  wire logic [imufd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [imufd_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,

  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                frame_good_o,
  output logic [7:0]                          frame_kind_o,
  output logic signed [16:0]                  roll_out_o,
  output logic signed [16:0]                  pitch_out_o,
  output logic signed [15:0]                  yaw_out_o,
  output logic                                angles_valid_o,
  output logic                                static_flag_o,
  output logic [31:0]                         good_count_o,
  output logic [31:0]                         bad_count_o
);
  import imufd_pkg::*;

  localparam int unsigned F  = EMA_FRACTION_BITS;
  localparam int unsigned SW = F + 18;   // roll and pitch EMA state
  localparam int unsigned DW = F + 19;   // roll and pitch EMA difference
  localparam int unsigned YW = F + 16;   // yaw EMA state, wraps at one turn
  localparam logic [SW:0]   HALF_S = (SW + 1)'(1) << (F - 1);
  localparam logic [YW-1:0] HALF_Y = YW'(1) << (F - 1);

  // Configuration registers.
  logic [15:0] alpha_q;
  logic [14:0] pitch_dz_q, yaw_dz_q;
  logic [31:0] limit_q;
  logic [7:0]  header_q, angle_code_q, gyro_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      <= RST_EMA_ALPHA;
      pitch_dz_q   <= RST_PITCH_DZ;
      yaw_dz_q     <= RST_YAW_DZ;
      limit_q      <= RST_STATIC_LIMIT;
      header_q     <= RST_HEADER;
      angle_code_q <= RST_ANGLE_CODE;
      gyro_code_q  <= RST_GYRO_CODE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_EMA_ALPHA:    alpha_q      <= cfg_data_i[15:0];
        CFG_PITCH_DZ:     pitch_dz_q   <= cfg_data_i[14:0];
        CFG_YAW_DZ:       yaw_dz_q     <= cfg_data_i[14:0];
        CFG_STATIC_LIMIT: limit_q      <= cfg_data_i[31:0];
        CFG_HEADER:       header_q     <= cfg_data_i[7:0];
        CFG_ANGLE_CODE:   angle_code_q <= cfg_data_i[7:0];
        CFG_GYRO_CODE:    gyro_code_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Byte collection
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] pos_q;
  logic [7:0]       sum_q;
  logic [7:0]       store_q [STORE_DEPTH];
  phase_e           phase_q, phase_d;
  logic             out_valid_q;

  logic             in_fire, close_fire;
  logic [POS_W-1:0] store_idx;

  // The closing byte starts the filter sequence, so it waits until the
  // sequence is free and the output register is empty or draining.
  assign in_stall_o = (pos_q == POS_LAST) &&
                      !((phase_q == PH_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_fire    = in_valid_i && !in_stall_o;
  assign close_fire = in_fire && (pos_q == POS_LAST);
  assign store_idx  = pos_q - POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else if (in_fire) begin
      if (pos_q == '0) begin
        if (rx_byte_i == header_q) begin
          sum_q <= rx_byte_i;
          pos_q <= POS_W'(1);
        end
      end else if (pos_q == POS_LAST) begin
        pos_q <= '0;
      end else begin
        sum_q <= sum_q + rx_byte_i;
        pos_q <= pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (pos_q != '0) && (pos_q != POS_LAST) &&
        (store_idx < POS_W'(STORE_DEPTH))) begin
      store_q[store_idx[STORE_IDX_W-1:0]] <= rx_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic prep_en, diff_en, mul_en, acc_en, hold_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= PH_IDLE;
    else         phase_q <= phase_d;
  end

  always_comb begin
    phase_d = phase_q;
    prep_en = 1'b0;
    diff_en = 1'b0;
    mul_en  = 1'b0;
    acc_en  = 1'b0;
    hold_en = 1'b0;
    case (phase_q)
      PH_IDLE: if (close_fire) phase_d = PH_PREP;
      PH_PREP: begin prep_en = 1'b1; phase_d = PH_DIFF; end
      PH_DIFF: begin diff_en = 1'b1; phase_d = PH_MUL;  end
      PH_MUL:  begin mul_en  = 1'b1; phase_d = PH_ACC;  end
      PH_ACC:  begin acc_en  = 1'b1; phase_d = PH_HOLD; end
      PH_HOLD: begin hold_en = 1'b1; phase_d = PH_IDLE; end
      default: phase_d = PH_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame capture on the closing byte
  // --------------------------------------------------------------------------
  logic [7:0]        kind_q;
  logic              good_q, ang_q, gyr_q;
  logic signed [15:0] raw_roll_q, raw_pitch_q, raw_yaw_q;
  logic [31:0]       gc_q, bc_q;
  logic              good_d;

  assign good_d = (store_q[0] inside {[TYPE_LOW:TYPE_HIGH]}) && (sum_q == rx_byte_i);

  always_ff @(posedge clk_i) begin
    if (close_fire) begin
      kind_q      <= store_q[0];
      good_q      <= good_d;
      ang_q       <= good_d && (store_q[0] == angle_code_q);
      gyr_q       <= good_d && (store_q[0] != angle_code_q) &&
                     (store_q[0] == gyro_code_q);
      raw_roll_q  <= {store_q[2], store_q[1]};
      raw_pitch_q <= {store_q[4], store_q[3]};
      raw_yaw_q   <= {store_q[6], store_q[5]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q <= '0;
      bc_q <= '0;
    end else if (close_fire) begin
      if (good_d) begin
        if (gc_q != '1) gc_q <= gc_q + 32'd1;
      end else if (bc_q != '1) begin
        bc_q <= bc_q + 32'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Prepare: clamp, offsets, gyro squares
  // --------------------------------------------------------------------------
  logic               valid_q, first_q, still_q;
  logic signed [15:0] off_roll_q, off_pitch_q, off_yaw_q;
  logic signed [15:0] clamp_pitch, use_roll, use_pitch, use_yaw;
  logic signed [16:0] roll_q, pitch_q;
  logic signed [15:0] yaw_q;
  logic signed [31:0] sqx_full, sqy_full, sqz_full;
  logic [30:0]        sqx_q, sqy_q, sqz_q;

  always_comb begin
    if (raw_pitch_q > PITCH_LIMIT)       clamp_pitch = PITCH_LIMIT;
    else if (raw_pitch_q < -PITCH_LIMIT) clamp_pitch = -PITCH_LIMIT;
    else                                 clamp_pitch = raw_pitch_q;
    // The first angle frame is its own offset.
    use_roll  = valid_q ? off_roll_q  : raw_roll_q;
    use_pitch = valid_q ? off_pitch_q : clamp_pitch;
    use_yaw   = valid_q ? off_yaw_q   : raw_yaw_q;
  end

  assign sqx_full = raw_roll_q  * raw_roll_q;
  assign sqy_full = raw_pitch_q * raw_pitch_q;
  assign sqz_full = raw_yaw_q   * raw_yaw_q;

  always_ff @(posedge clk_i) begin
    if (prep_en) begin
      roll_q  <= {raw_roll_q[15], raw_roll_q} - {use_roll[15], use_roll};
      pitch_q <= {clamp_pitch[15], clamp_pitch} - {use_pitch[15], use_pitch};
      yaw_q   <= raw_yaw_q - use_yaw;
      first_q <= !valid_q;
      sqx_q   <= sqx_full[30:0];
      sqy_q   <= sqy_full[30:0];
      sqz_q   <= sqz_full[30:0];
    end
    if (prep_en && ang_q && !valid_q) begin
      off_roll_q  <= raw_roll_q;
      off_pitch_q <= clamp_pitch;
      off_yaw_q   <= raw_yaw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      still_q <= 1'b0;
    end else begin
      if (prep_en && ang_q) valid_q <= 1'b1;
      if (diff_en && gyr_q) begin
        still_q <= ({2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q}) <
                   {1'b0, limit_q};
      end
    end
  end

  // --------------------------------------------------------------------------
  // EMA: difference, multiply, accumulate
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sr_q, sp_q;
  logic signed [YW-1:0] sy_q;
  logic signed [DW-1:0] qr, qp, dr_q, dp_q;
  logic signed [YW-1:0] qy, dy_q;
  logic signed [16:0]   alpha_s;
  logic signed [DW+16:0] pr_q, pp_q;
  logic signed [YW+16:0] py_q;

  assign qr = {{(DW - 17 - F){roll_q[16]}},  roll_q,  {F{1'b0}}};
  assign qp = {{(DW - 17 - F){pitch_q[16]}}, pitch_q, {F{1'b0}}};
  assign qy = {yaw_q, {F{1'b0}}};
  assign alpha_s = {1'b0, alpha_q};

  always_ff @(posedge clk_i) begin
    if (diff_en) begin
      dr_q <= qr - {{(DW - SW){sr_q[SW-1]}}, sr_q};
      dp_q <= qp - {{(DW - SW){sp_q[SW-1]}}, sp_q};
      // Yaw difference wraps at one turn.
      dy_q <= qy - sy_q;
    end
    if (mul_en) begin
      pr_q <= dr_q * alpha_s;
      pp_q <= dp_q * alpha_s;
      py_q <= dy_q * alpha_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= '0;
      sp_q <= '0;
      sy_q <= '0;
    end else if (acc_en && ang_q) begin
      if (first_q) begin
        sr_q <= qr[SW-1:0];
        sp_q <= qp[SW-1:0];
        sy_q <= qy;
      end else begin
        // Dropping the low 16 product bits of a signed value floors it.
        sr_q <= sr_q + pr_q[SW+15:16];
        sp_q <= sp_q + pp_q[SW+15:16];
        sy_q <= sy_q + py_q[YW+15:16];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Hold: round, deadzones, output register
  // --------------------------------------------------------------------------
  logic signed [16:0] hr_q, hp_q;
  logic signed [15:0] hy_q;
  logic signed [16:0] hr_d, hp_d;
  logic signed [15:0] hy_d;
  logic [SW:0]        rnd_r, rnd_p;
  logic [YW-1:0]      rnd_y;
  logic signed [16:0] vr, vp;
  logic signed [15:0] vy;
  logic signed [17:0] dzp;
  logic signed [16:0] dzy;
  logic [17:0]        mag_p;
  logic [16:0]        mag_y;

  always_comb begin
    rnd_r = {sr_q[SW-1], sr_q} + HALF_S;
    rnd_p = {sp_q[SW-1], sp_q} + HALF_S;
    rnd_y = sy_q + HALF_Y;
    vr    = rnd_r[F+16:F];
    vp    = rnd_p[F+16:F];
    vy    = rnd_y[F+15:F];
    dzp   = {vp[16], vp} - {hp_q[16], hp_q};
    dzy   = {vy[15], vy} - {hy_q[15], hy_q};
    mag_p = dzp[17] ? 18'(-dzp) : 18'(dzp);
    mag_y = dzy[16] ? 17'(-dzy) : 17'(dzy);
    hr_d  = hr_q;
    hp_d  = hp_q;
    hy_d  = hy_q;
    if (ang_q) begin
      hr_d = vr;
      if (mag_p > {3'b000, pitch_dz_q}) hp_d = vp;
      if (mag_y > {2'b00, yaw_dz_q})    hy_d = vy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_q        <= '0;
      hp_q        <= '0;
      hy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hold_en) begin
        hr_q <= hr_d;
        hp_q <= hp_d;
        hy_q <= hy_d;
      end
      if (hold_en)           out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_en) begin
      frame_good_o   <= good_q;
      frame_kind_o   <= kind_q;
      roll_out_o     <= hr_d;
      pitch_out_o    <= hp_d;
      yaw_out_o      <= hy_d;
      angles_valid_o <= valid_q;
      static_flag_o  <= still_q;
      good_count_o   <= gc_q;
      bad_count_o    <= bc_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : imu_frame_deframer_angle_filter_top
`default_nettype wire

### tb/sv/imufd_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imufd_frame_checker
// Predicts the result of every IMU frame and compares it with the block.
// ----------------------------------------------------------------------------
// Watches the configuration port and both item channels. Every accepted byte
// goes through a local deframer and angle filter; every completed frame
// queues the result it should produce. Accepted result items are compared
// field by field with the oldest queued frame result.
module imufd_frame_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_we_i,
  input  wire logic [imufd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [imufd_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  input  wire logic                               in_valid_i,
  input  wire logic                               in_stall_i,
  input  wire logic [7:0]                         rx_byte_i,

  input  wire logic                               out_valid_i,
  input  wire logic                               out_stall_i,
  input  wire logic                               frame_good_i,
  input  wire logic [7:0]                         frame_kind_i,
  input  wire logic signed [16:0]                 roll_i,
  input  wire logic signed [16:0]                 pitch_i,
  input  wire logic signed [15:0]                 yaw_i,
  input  wire logic                               angles_valid_i,
  input  wire logic                               static_flag_i,
  input  wire logic [31:0]                        good_count_i,
  input  wire logic [31:0]                        bad_count_i,

  output int unsigned                             fail_count_o,
  output int unsigned                             pending_o,
  output int unsigned                             checked_o
);
  import imufd_pkg::*;

  // The filter weight is always an unsigned Q0.16 value.
  localparam int unsigned ALPHA_BITS = 16;

  typedef struct packed {
    logic               good;
    logic [7:0]         kind;
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic signed [15:0] yaw;
    logic               valid;
    logic               still;
    logic [31:0]        good_total;
    logic [31:0]        bad_total;
  } frame_result_t;

  // Local copy of the configuration.
  logic [15:0] alpha_q;
  logic [14:0] pitch_dz_q;
  logic [14:0] yaw_dz_q;
  logic [31:0] rate_limit_q;
  logic [7:0]  header_q;
  logic [7:0]  angle_code_q;
  logic [7:0]  gyro_code_q;

  // Deframer and filter state.
  int unsigned pos_q;
  logic [7:0]  bytes_q [0:8];
  logic [7:0]  sum_q;
  longint      off_roll, off_pitch, off_yaw;
  longint      ema_roll, ema_pitch, ema_yaw;
  longint      hold_roll, hold_pitch, hold_yaw;
  bit          seen_angle, first_angle, still;
  logic [31:0] good_total, bad_total;

  frame_result_t awaited_frames [$];
  int unsigned   fails   = 0;
  int unsigned   checked = 0;

  // Sign-extends the low bits of a value, that is, wraps it modulo 2^bits.
  function automatic longint wrap_to(longint v, int unsigned bits);
    longint m;
    m = (longint'(1) << bits) - 1;
    v = v & m;
    if (v[bits-1]) v = v - (longint'(1) << bits);
    return v;
  endfunction

  function automatic longint word_of(int unsigned i);
    logic signed [15:0] w;
    w = {bytes_q[i+1], bytes_q[i]};
    return longint'(w);
  endfunction

  function automatic longint round_ema(longint s);
    return (s + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint ema_step(longint s, longint d);
    return s + ((d * longint'(alpha_q)) >>> ALPHA_BITS);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic angle_update();
    longint r, p, y, dr, dp, dy, v, unit;
    unit = longint'(1) << FRAC_BITS;
    r = word_of(1);
    p = word_of(3);
    y = word_of(5);
    if (p > longint'(PITCH_LIMIT)) p = longint'(PITCH_LIMIT);
    if (p < -longint'(PITCH_LIMIT)) p = -longint'(PITCH_LIMIT);
    // The first angle frame ever accepted becomes the zero reference.
    if (!seen_angle) begin
      off_roll    = r;
      off_pitch   = p;
      off_yaw     = y;
      ema_roll    = 0;
      ema_pitch   = 0;
      ema_yaw     = 0;
      first_angle = 1'b1;
    end
    dr = r - off_roll;
    dp = p - off_pitch;
    dy = wrap_to(y - off_yaw, 16);
    if (first_angle) begin
      ema_roll    = dr * unit;
      ema_pitch   = dp * unit;
      ema_yaw     = dy * unit;
      first_angle = 1'b0;
    end else begin
      ema_roll  = ema_step(ema_roll, dr * unit - ema_roll);
      ema_pitch = ema_step(ema_pitch, dp * unit - ema_pitch);
      // Yaw moves along the short way around the circle.
      v         = wrap_to(dy * unit - ema_yaw, 16 + FRAC_BITS);
      ema_yaw   = wrap_to(ema_step(ema_yaw, v), 16 + FRAC_BITS);
    end
    v = round_ema(ema_pitch);
    if (magnitude(v - hold_pitch) > longint'(pitch_dz_q)) hold_pitch = v;
    // The yaw deadzone uses the plain difference, without wrapping.
    v = wrap_to(round_ema(ema_yaw), 16);
    if (magnitude(v - hold_yaw) > longint'(yaw_dz_q)) hold_yaw = v;
    hold_roll  = round_ema(ema_roll);
    seen_angle = 1'b1;
  endtask

  task automatic gyro_update();
    longint gx, gy, gz;
    gx = word_of(1);
    gy = word_of(3);
    gz = word_of(5);
    still = (gx * gx + gy * gy + gz * gz) < longint'(rate_limit_q);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t res;
    logic [7:0]    kind;
    bit            good;
    if (pos_q == 0) begin
      // Outside a frame only the header byte matters.
      if (b == header_q) begin
        sum_q = b;
        pos_q = 1;
      end
    end else if (pos_q < FRAME_LEN - 1) begin
      bytes_q[pos_q-1] = b;
      sum_q            = sum_q + b;
      pos_q++;
    end else begin
      pos_q = 0;
      kind  = bytes_q[0];
      good  = (kind >= TYPE_LOW) && (kind <= TYPE_HIGH) && (sum_q == b);
      if (good) begin
        if (kind == angle_code_q) angle_update();
        else if (kind == gyro_code_q) gyro_update();
        if (good_total != '1) good_total++;
      end else if (bad_total != '1) begin
        bad_total++;
      end
      res.good       = good;
      res.kind       = kind;
      res.roll       = hold_roll[16:0];
      res.pitch      = hold_pitch[16:0];
      res.yaw        = hold_yaw[15:0];
      res.valid      = seen_angle;
      res.still      = still;
      res.good_total = good_total;
      res.bad_total  = bad_total;
      awaited_frames.push_back(res);
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      alpha_q      = RST_EMA_ALPHA;
      pitch_dz_q   = RST_PITCH_DZ;
      yaw_dz_q     = RST_YAW_DZ;
      rate_limit_q = RST_STATIC_LIMIT;
      header_q     = RST_HEADER;
      angle_code_q = RST_ANGLE_CODE;
      gyro_code_q  = RST_GYRO_CODE;
      pos_q        = 0;
      sum_q        = '0;
      for (int k = 0; k < 9; k++) bytes_q[k] = '0;
      off_roll     = 0;
      off_pitch    = 0;
      off_yaw      = 0;
      ema_roll     = 0;
      ema_pitch    = 0;
      ema_yaw      = 0;
      hold_roll    = 0;
      hold_pitch   = 0;
      hold_yaw     = 0;
      seen_angle   = 1'b0;
      first_angle  = 1'b1;
      still        = 1'b0;
      good_total   = '0;
      bad_total    = '0;
      awaited_frames.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_EMA_ALPHA:    alpha_q      = cfg_data_i[15:0];
          CFG_PITCH_DZ:     pitch_dz_q   = cfg_data_i[14:0];
          CFG_YAW_DZ:       yaw_dz_q     = cfg_data_i[14:0];
          CFG_STATIC_LIMIT: rate_limit_q = cfg_data_i[31:0];
          CFG_HEADER:       header_q     = cfg_data_i[7:0];
          CFG_ANGLE_CODE:   angle_code_q = cfg_data_i[7:0];
          CFG_GYRO_CODE:    gyro_code_q  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (awaited_frames.size() == 0) begin
          $error("result item arrived with no completed frame pending");
          fails++;
        end else begin
          want = awaited_frames.pop_front();
          compare_field("frame_good", longint'(want.good), longint'(frame_good_i));
          compare_field("frame_kind", longint'(want.kind), longint'(frame_kind_i));
          compare_field("roll_out", longint'($signed(want.roll)), longint'(roll_i));
          compare_field("pitch_out", longint'($signed(want.pitch)), longint'(pitch_i));
          compare_field("yaw_out", longint'($signed(want.yaw)), longint'(yaw_i));
          compare_field("angles_valid", longint'(want.valid), longint'(angles_valid_i));
          compare_field("static_flag", longint'(want.still), longint'(static_flag_i));
          compare_field("good_count", longint'(want.good_total), longint'(good_count_i));
          compare_field("bad_count", longint'(want.bad_total), longint'(bad_count_i));
          checked++;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= awaited_frames.size();
    checked_o    <= checked;
  end

endmodule : imufd_frame_checker
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the IMU frame deframer and angle filter.
// ----------------------------------------------------------------------------
// Feeds a few hand-built frames, then phases of random frames under several
// filter settings and idle patterns: well-formed angle and gyro frames with
// tracking and extreme values, mixed with foreign types, bad checksums,
// truncated frames and stray bytes. A checker beside the block predicts and
// compares every result item; this module only drives and reports.
module tb;
  import imufd_pkg::*;

  localparam int unsigned EMA_BITS      = 16;
  localparam int unsigned CLK_HALF      = 10;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_FRAMES  = 21;
  localparam int unsigned IDLE_HEAVY    = 66;
  localparam int unsigned IDLE_BOTH     = 29;

  typedef struct {
    logic [15:0] alpha;
    logic [14:0] pitch_dz;
    logic [14:0] yaw_dz;
    logic [31:0] rate_limit;
    logic [7:0]  header;
    logic [7:0]  angle_code;
    logic [7:0]  gyro_code;
  } filter_cfg_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic [7:0]            rx_byte    = '0;
  logic                  out_stall  = 1'b0;

  logic                  in_stall;
  logic                  out_valid;
  logic                  frame_good;
  logic [7:0]            frame_kind;
  logic signed [16:0]    roll_out;
  logic signed [16:0]    pitch_out;
  logic signed [15:0]    yaw_out;
  logic                  angles_valid;
  logic                  static_flag;
  logic [31:0]           good_count;
  logic [31:0]           bad_count;

  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           checked;

  int unsigned           gap_pct    = 0;
  int unsigned           stall_pct  = 0;
  bit                    hold_req   = 1'b0;
  int unsigned           cycles     = 0;
  int unsigned           bytes_sent = 0;
  int unsigned           frames_sent = 0;
  logic [15:0]           trend [3];
  filter_cfg_t           cur_cfg;

  imu_frame_deframer_angle_filter_top #(
    .EMA_FRACTION_BITS(EMA_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .frame_good_o  (frame_good),
    .frame_kind_o  (frame_kind),
    .roll_out_o    (roll_out),
    .pitch_out_o   (pitch_out),
    .yaw_out_o     (yaw_out),
    .angles_valid_o(angles_valid),
    .static_flag_o (static_flag),
    .good_count_o  (good_count),
    .bad_count_o   (bad_count)
  );

  imufd_frame_checker #(
    .FRAC_BITS(EMA_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .frame_good_i  (frame_good),
    .frame_kind_i  (frame_kind),
    .roll_i        (roll_out),
    .pitch_i       (pitch_out),
    .yaw_i         (yaw_out),
    .angles_valid_i(angles_valid),
    .static_flag_i (static_flag),
    .good_count_i  (good_count),
    .bad_count_i   (bad_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin : clock_gen
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Run timed out after %0d cycles.", cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, or one long hold-off when requested.
  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stops sending and waits until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(input filter_cfg_t c);
    cfg_reg_e r;
    r = r.first();
    do begin
      cfg_we  <= 1'b1;
      cfg_idx <= r;
      case (r)
        CFG_EMA_ALPHA:    cfg_data <= CFG_DATA_W'(c.alpha);
        CFG_PITCH_DZ:     cfg_data <= CFG_DATA_W'(c.pitch_dz);
        CFG_YAW_DZ:       cfg_data <= CFG_DATA_W'(c.yaw_dz);
        CFG_STATIC_LIMIT: cfg_data <= CFG_DATA_W'(c.rate_limit);
        CFG_HEADER:       cfg_data <= CFG_DATA_W'(c.header);
        CFG_ANGLE_CODE:   cfg_data <= CFG_DATA_W'(c.angle_code);
        CFG_GYRO_CODE:    cfg_data <= CFG_DATA_W'(c.gyro_code);
        default:          cfg_data <= '0;
      endcase
      @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // Sends the first 'cut' bytes of a frame; a nonzero flip spoils the checksum.
  task automatic send_frame(input logic [7:0] kind, input logic [15:0] w0, w1, w2,
                            input logic [7:0] x0, x1, flip, input int unsigned cut);
    logic [7:0]  fr [FRAME_LEN];
    logic [7:0]  sum;
    int unsigned k;
    fr[0] = cur_cfg.header;
    fr[1] = kind;
    fr[2] = w0[7:0];
    fr[3] = w0[15:8];
    fr[4] = w1[7:0];
    fr[5] = w1[15:8];
    fr[6] = w2[7:0];
    fr[7] = w2[15:8];
    fr[8] = x0;
    fr[9] = x1;
    sum = '0;
    for (k = 0; k < FRAME_LEN - 1; k++) sum = sum + fr[k];
    fr[FRAME_LEN-1] = sum ^ flip;
    for (k = 0; k < cut; k++) send_byte(fr[k]);
  endtask

  task automatic send_random_frame();
    logic [7:0]  kind;
    logic [7:0]  flip;
    logic [15:0] w [3];
    int unsigned pick, span, k, cut;
    pick = $urandom_range(99, 0);
    if (pick < 45)      kind = cur_cfg.angle_code;
    else if (pick < 70) kind = cur_cfg.gyro_code;
    else if (pick < 85) kind = TYPE_LOW + 8'($urandom_range(10, 0));
    else                kind = 8'($urandom());
    for (k = 0; k < 3; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        w[k] = 16'($urandom());
      end else if (pick < 27) begin
        case ($urandom_range(3, 0))
          0:       w[k] = 16'h8000;
          1:       w[k] = 16'h7FFF;
          2:       w[k] = 16'h0000;
          default: w[k] = 16'hFFFF;
        endcase
      end else if (pick < 45) begin
        // Small rates so that the static threshold is crossed both ways.
        w[k] = 16'($urandom_range(6, 0));
        if ($urandom_range(1, 0) != 0) w[k] = -w[k];
      end else begin
        // A slowly drifting angle, with small steps for the deadzones.
        span    = (pick < 70) ? 40 : 4000;
        trend[k] = trend[k] + 16'($urandom_range(span, 0)) - 16'(span / 2);
        w[k]    = trend[k];
      end
    end
    flip = ($urandom_range(99, 0) < 12) ? 8'($urandom_range(255, 1)) : 8'h00;
    cut  = ($urandom_range(99, 0) < 4) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN;
    send_frame(kind, w[0], w[1], w[2], 8'($urandom()), 8'($urandom()), flip, cut);
    frames_sent++;
  endtask

  initial begin : stimulus
    filter_cfg_t plan [NUM_PHASES];
    int unsigned p, f;
    cur_cfg = '{RST_EMA_ALPHA, RST_PITCH_DZ, RST_YAW_DZ, RST_STATIC_LIMIT,
                RST_HEADER, RST_ANGLE_CODE, RST_GYRO_CODE};
    for (f = 0; f < 3; f++) trend[f] = 16'($urandom());
    plan[0] = cur_cfg;
    plan[1] = '{16'hFFFF, 15'd0, 15'd0, 32'hFFFF_FFFF, 8'h55, 8'h53, 8'h52};
    plan[2] = '{16'h0000, 15'h7FFF, 15'h7FFF, 32'd0, 8'hAA, 8'h50, 8'h5A};
    plan[3] = '{16'h8000, 15'd5, 15'd300, 32'd1000, 8'h00, 8'h5A, 8'h50};
    // Type codes outside the legal range never match a good frame.
    plan[4] = '{16'($urandom()), 15'($urandom_range(100, 0)), 15'($urandom_range(100, 0)),
                32'($urandom()), 8'hFF, 8'h00, 8'hFF};
    // Equal codes: the angle path wins.
    plan[5] = '{16'd1, 15'd1, 15'd1, 32'd5, 8'h55, 8'h53, 8'h53};
    plan[6] = '{16'($urandom()), 15'($urandom_range(200, 0)), 15'($urandom_range(200, 0)),
                32'($urandom_range(4000, 0)), 8'($urandom()),
                TYPE_LOW + 8'($urandom_range(10, 0)), TYPE_LOW + 8'($urandom_range(10, 0))};
    plan[7] = '{RST_EMA_ALPHA, RST_PITCH_DZ, RST_YAW_DZ, 32'h0010_0000,
                RST_HEADER, RST_ANGLE_CODE, RST_GYRO_CODE};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hand-built start: stray bytes at both extremes, an angle frame with the
    // header value inside its data and out-of-range pitch, and a gyro frame
    // at full negative rate on every axis.
    send_byte(8'hFF);
    send_frame(RST_ANGLE_CODE, 16'h8000, 16'h7FFF, 16'h7FFF, RST_HEADER, 8'h00, 8'h00,
               FRAME_LEN);
    send_frame(RST_GYRO_CODE, 16'h8000, 16'h8000, 16'h8000, 8'hFF, 8'h00, 8'h00, FRAME_LEN);
    send_byte(8'h00);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_settings(plan[p]);
      case (p % 4)
        0:       begin gap_pct = 0;          stall_pct = 0;          end
        1:       begin gap_pct = IDLE_HEAVY; stall_pct = 0;          end
        2:       begin gap_pct = 0;          stall_pct = IDLE_HEAVY; end
        default: begin gap_pct = IDLE_BOTH;  stall_pct = IDLE_BOTH;  end
      endcase
      for (f = 0; f < PHASE_FRAMES; f++) begin
        if (p == 0 && f == PHASE_FRAMES / 2) hold_req = 1'b1;
        if (p == 5 && f == PHASE_FRAMES / 2) drain();
        if ($urandom_range(99, 0) < 8) begin
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom()));
        end
        send_random_frame();
      end
      drain();
    end

    $display("Drove %0d bytes in %0d random frames over %0d filter settings and four idle",
             bytes_sent, frames_sent, NUM_PHASES);
    $display("patterns, with one long output hold-off; %0d result items compared.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : tb
`default_nettype wire
